@@ rtl/core/ipv4_dotted_quad_validator_unit_macros.svh @@
// assertion macros shared by the validator checker
`ifndef IPV4_DOTTED_QUAD_VALIDATOR_UNIT_MACROS_SVH
`define IPV4_DOTTED_QUAD_VALIDATOR_UNIT_MACROS_SVH

// implication in the same cycle, off while reset is applied
`define IVQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

// implication in the next cycle, off while reset is applied
`define IVQ_ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next cycle implication failed");

// implication in the next cycle, checked through reset as well
`define IVQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`endif

@@ rtl/core/ivq_pkg.sv @@
// types, constants and class bounds for the dotted quad validator
package ivq_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned VALUE_W  = 9;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned OCTETS   = 4;
    localparam int unsigned CLASSES  = 4;

    localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [VALUE_W-1:0] VALUE_SAT  = 9'd256;
    localparam logic [VALUE_W-1:0] OCTET_MAX  = 9'd255;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

    typedef logic [7:0] octet_t;
    typedef octet_t [OCTETS-1:0] quad_t;

    localparam quad_t CLASS_LOW [CLASSES] = '{
        '{8'd1,   8'd0, 8'd0, 8'd1},
        '{8'd128, 8'd1, 8'd0, 8'd1},
        '{8'd192, 8'd0, 8'd1, 8'd1},
        '{8'd224, 8'd0, 8'd0, 8'd0}
    };
    localparam quad_t CLASS_HIGH [CLASSES] = '{
        '{8'd126, 8'd255, 8'd255, 8'd254},
        '{8'd191, 8'd255, 8'd255, 8'd254},
        '{8'd223, 8'd255, 8'd254, 8'd254},
        '{8'd239, 8'd255, 8'd255, 8'd255}
    };

    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_DOT,
        TOK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t            kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } token_t;

    // octet k of the quad is index k, first field written first
    function automatic logic class_hit(input quad_t q);
        logic hit;
        logic in_range;
        hit = 1'b0;
        for (int c = 0; c < CLASSES; c++) begin
            in_range = 1'b1;
            for (int k = 0; k < OCTETS; k++) begin
                if (q[k] < CLASS_LOW[c][OCTETS-1-k] || q[k] > CLASS_HIGH[c][OCTETS-1-k]) begin
                    in_range = 1'b0;
                end
            end
            hit = hit | in_range;
        end
        return hit;
    endfunction

endpackage

@@ rtl/core/ivq_front.sv @@
// input stage: classifies each character into a token and registers it
module ivq_front
    import ivq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_last,
    output logic              tok_valid,
    input  logic              tok_ready,
    output token_t            tok_data
);

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;
    logic   take;

    assign s_ready   = !valid_reg || tok_ready;
    assign take      = s_valid && s_ready;
    assign tok_valid = valid_reg;
    assign tok_data  = tok_reg;

    always_comb begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        if (tok_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next     = 1'b1;
            tok_next.last  = s_last;
            tok_next.digit = DIGIT_W'(s_character - CHAR_ZERO);
            if (s_character == CHAR_DOT) begin
                tok_next.kind = TOK_DOT;
            end else if (s_character >= CHAR_ZERO && s_character <= CHAR_NINE) begin
                tok_next.kind = TOK_DIGIT;
            end else begin
                tok_next.kind = TOK_OTHER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        tok_reg <= tok_next;
    end

endmodule

@@ rtl/core/ivq_fifo.sv @@
// token queue between the classifier and the field checker
module ivq_fifo
    import ivq_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_data
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    token_t           mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/core/ivq_back.sv @@
// field accumulation, octet store, class check and result register
module ivq_back
    import ivq_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   tok_valid,
    output logic   tok_ready,
    input  token_t tok_data,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_valid_res
);

    logic [VALUE_W-1:0] value_reg, value_next;
    logic [1:0]         digits_reg, digits_next;
    logic               zero_reg, zero_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               malformed_reg, malformed_next;
    quad_t              octet_reg, octet_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_res_reg, out_res_next;
    logic               fire;
    logic [11:0]        product;
    logic               bad;

    assign tok_ready   = !out_valid_reg || m_ready;
    assign fire        = tok_valid && tok_ready;
    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_res_reg;

    always_comb begin
        value_next     = value_reg;
        digits_next    = digits_reg;
        zero_next      = zero_reg;
        count_next     = count_reg;
        malformed_next = malformed_reg;
        octet_next     = octet_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        product        = '0;
        bad            = 1'b0;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            unique case (tok_data.kind)
                TOK_DIGIT: begin
                    if (digits_reg == 2'd0 && tok_data.digit == '0) begin
                        zero_next = 1'b1;
                    end
                    product    = 12'(value_reg) * 12'd10 + 12'(tok_data.digit);
                    value_next = (product > 12'(VALUE_SAT)) ? VALUE_SAT : product[VALUE_W-1:0];
                    if (digits_reg != 2'd3) begin
                        digits_next = digits_reg + 2'd1;
                    end
                end
                TOK_DOT: begin
                    bad = digits_reg == 2'd0 || (zero_reg && digits_reg > 2'd1)
                        || value_reg > OCTET_MAX;
                    if (bad || count_reg >= FULL_COUNT) begin
                        malformed_next = 1'b1;
                    end else begin
                        octet_next[count_reg[1:0]] = value_reg[7:0];
                        count_next = count_reg + 3'd1;
                    end
                    value_next  = '0;
                    digits_next = '0;
                    zero_next   = 1'b0;
                end
                TOK_OTHER: begin
                    malformed_next = 1'b1;
                end
                default: begin
                    malformed_next = 1'b1;
                end
            endcase
            if (tok_data.last) begin
                bad = digits_next == 2'd0 || (zero_next && digits_next > 2'd1)
                    || value_next > OCTET_MAX;
                if (bad || count_next >= FULL_COUNT) begin
                    malformed_next = 1'b1;
                end else begin
                    octet_next[count_next[1:0]] = value_next[7:0];
                    count_next = count_next + 3'd1;
                end
                out_valid_next = 1'b1;
                out_res_next   = !malformed_next && count_next == FULL_COUNT
                    && class_hit(octet_next);
                value_next     = '0;
                digits_next    = '0;
                zero_next      = 1'b0;
                count_next     = '0;
                malformed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg     <= '0;
            digits_reg    <= '0;
            zero_reg      <= 1'b0;
            count_reg     <= '0;
            malformed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            value_reg     <= value_next;
            digits_reg    <= digits_next;
            zero_reg      <= zero_next;
            count_reg     <= count_next;
            malformed_reg <= malformed_next;
            out_valid_reg <= out_valid_next;
        end
        octet_reg   <= octet_next;
        out_res_reg <= out_res_next;
    end

endmodule

@@ rtl/core/ipv4_dotted_quad_validator_unit.sv @@
// top level of the dotted quad address validator
// usage:
//   s_ channel carries the address text, one ascii byte per transfer on
//   s_character, with s_last high on the final byte of each string.
//   m_ channel carries one transfer per string on m_valid_res: 1 when the
//   text is four well formed decimal octets inside class a, b, c or d.
//   throughput is one character per cycle while no result stalls; the
//   classifier, queue and field checker each take a new character as
//   they pass one on. m_valid rises once the last character has passed
//   the classifier register, then the queue slot and then the result
//   register. when m_valid is high and m_ready low the result register
//   holds and the field checker stops; the classifier register and the
//   queue then absorb up to QUEUE_DEPTH + 1 more characters before
//   s_ready drops. a taken result frees the register in the same cycle.
//   aresetn is synchronous, active low; it empties the queue, drops
//   m_valid and clears any partly received string.
module ipv4_dotted_quad_validator_unit
    import ivq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_valid_res
);

    logic   front_valid;
    logic   front_ready;
    token_t front_tok;
    logic   q_valid;
    logic   q_ready;
    token_t q_tok;

    ivq_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .tok_valid   (front_valid),
        .tok_ready   (front_ready),
        .tok_data    (front_tok)
    );

    ivq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_tok),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_tok)
    );

    ivq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tok_valid   (q_valid),
        .tok_ready   (q_ready),
        .tok_data    (q_tok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res)
    );

endmodule

@@ rtl/core/ivq_checker.sv @@
// port level checker for the validator, bound to the top level
`include "ipv4_dotted_quad_validator_unit_macros.svh"

module ivq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_last,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_valid_res
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       last_in;
    logic       res_out;

    assign last_in = s_valid && s_ready && s_last;
    assign res_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (last_in && !res_out) begin
            pending_next = pending_reg + 8'd1;
        end else if (res_out && !last_in) begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // every result belongs to a string whose last character was taken
    `IVQ_ASSERT_IMPLY(a_result_has_string, aclk, aresetn, m_valid, pending_reg != 8'd0)

    // a stalled result keeps its value
    `IVQ_ASSERT_NEXT(a_result_held, aclk, m_valid && !m_ready, m_valid && $stable(m_valid_res), aresetn)

    // reset drops the result and opens the input
    `IVQ_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid && s_ready)

    // the input is ready when idle: nothing pending, no result shown and no recent s_valid
    `IVQ_ASSERT_IMPLY(a_idle_ready, aclk, aresetn, pending_reg == 8'd0 && !m_valid && !s_valid && $past(!s_valid) && $past(!s_valid, 2), s_ready)

endmodule

bind ipv4_dotted_quad_validator_unit ivq_checker u_ivq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_valid_res (m_valid_res)
);
